// ----- hdl/kstg_pkg.sv -----
// Shared types, constants and ROM tables for the keyed sine tone generator.
package kstg_pkg;

	localparam int SAMPLE_RATE_HZ  = 44100;
	localparam int PHASE_BITS      = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
	localparam int QTAB_DEPTH      = 1 << QUARTER_BITS;
	localparam int NUM_SEMITONES   = 12;

	localparam int AMP_W    = 15;
	localparam int LEN_W    = 16;
	localparam int MAG_W    = 15;
	localparam int SAMPLE_W = 16;
	localparam int OCT_W    = 4;
	localparam int SEMI_W   = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [OCT_W-1:0] OCTAVE_MAX  = OCT_W'(8);
	localparam logic [OCT_W-1:0] OCTAVE_BASE = OCT_W'(4);

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(16384);
	localparam int LEN_RAW = SAMPLE_RATE_HZ * 3 / 4;
	localparam logic [LEN_W-1:0] LEN_RESET =
		(LEN_RAW > 65535) ? LEN_W'(65535) : LEN_W'(LEN_RAW);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE     = 2'd1,
		CMD_OCT_DOWN = 2'd2,
		CMD_OCT_UP   = 2'd3
	} kstg_cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMPLITUDE   = 1'b0,
		REG_NOTE_LENGTH = 1'b1
	} kstg_reg_t;

	typedef struct packed {
		kstg_cmd_t          command;
		logic [SEMI_W-1:0]  semitone;
	} kstg_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sounding;
		logic                       note_end;
	} kstg_out_t;

	typedef logic [31:0]           freq_tab_t [NUM_SEMITONES];
	typedef logic [PHASE_BITS-1:0] step_tab_t [NUM_SEMITONES];
	typedef logic [MAG_W-1:0]      qsine_tab_t [QTAB_DEPTH];

	// Octave-4 note frequencies in Hz, unsigned Q16.16, A4 = 440 Hz.
	localparam freq_tab_t FREQ_Q16 = '{
		32'd17145893, 32'd18165441, 32'd19245614, 32'd20390018,
		32'd21602472, 32'd22887021, 32'd24247954, 32'd25689813,
		32'd27217409, 32'd28835840, 32'd30550508, 32'd32367136
	};

	// Octave-4 phase increments, rounded half up.
	function automatic step_tab_t build_step_tab();
		step_tab_t tab;
		logic [63:0] num;
		for (int s = 0; s < NUM_SEMITONES; s++) begin
			num = (64'(FREQ_Q16[s]) << (PHASE_BITS - 16)) + 64'(SAMPLE_RATE_HZ / 2);
			tab[s] = PHASE_BITS'(num / 64'(SAMPLE_RATE_HZ));
		end
		return tab;
	endfunction

	// Quarter-wave sine magnitude in Q15: Taylor series to x^11 in Q30.
	function automatic logic [MAG_W-1:0] qsine_entry(input logic [QUARTER_BITS:0] r);
		logic [63:0] x, x2, t3, t5, t7, t9, t11, pos, neg, s, q;
		x   = (64'(r) * HALF_PI_Q30) >> QUARTER_BITS;
		x2  = (x * x) >> 30;
		t3  = ((x * x2) >> 30) / 64'd6;
		t5  = ((t3 * x2) >> 30) / 64'd20;
		t7  = ((t5 * x2) >> 30) / 64'd42;
		t9  = ((t7 * x2) >> 30) / 64'd72;
		t11 = ((t9 * x2) >> 30) / 64'd110;
		pos = x + t5 + t9;
		neg = t3 + t7 + t11;
		s   = (pos > neg) ? pos - neg : 64'd0;
		q   = (s + 64'd16384) >> 15;
		return (q > 64'd32767) ? MAG_W'(32767) : q[MAG_W-1:0];
	endfunction

	function automatic qsine_tab_t build_qsine_tab();
		qsine_tab_t tab;
		for (int i = 0; i < QTAB_DEPTH; i++) begin
			tab[i] = qsine_entry((QUARTER_BITS + 1)'(i));
		end
		return tab;
	endfunction

	localparam step_tab_t  STEP_TAB   = build_step_tab();
	localparam qsine_tab_t QSINE_TAB  = build_qsine_tab();
	// Entry at the quarter point itself (sine of pi/2).
	localparam logic [MAG_W-1:0] QSINE_PEAK = qsine_entry((QUARTER_BITS + 1)'(QTAB_DEPTH));

endpackage

// ----- hdl/keyed_sine_tone_generator_unit.sv -----
// Top level: keyed DDS sine tone generator with note, octave and tick commands.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+--------------------------------
//  in      | in        | in_valid/in_stall  | kstg_in_t  (command, semitone)
//  out     | out       | out_valid/out_stall| kstg_out_t (sample, sounding, note_end)
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One word per cycle while no tick is held by a full, stalled output. A word
// is held in the input stage, where its command updates the oscillator state
// and a tick's sample is formed; the sample moves from there into the output
// register, which drives out_valid. Commands other than a tick give no word.
// The input stage stalls only while it holds a tick and the output register
// is full and stalled. Reset: octave 4, silence, amplitude 16384, note
// length 33075; cfg_ready is always high.
module keyed_sine_tone_generator_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  kstg_pkg::kstg_in_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output kstg_pkg::kstg_out_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kstg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kstg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// configuration
	logic [kstg_pkg::AMP_W-1:0]      amplitude_q;
	logic [kstg_pkg::LEN_W-1:0]      note_length_q;

	// oscillator state
	logic [kstg_pkg::PHASE_BITS-1:0] phase_q;
	logic [kstg_pkg::PHASE_BITS-1:0] phase_step_q;
	logic [kstg_pkg::LEN_W-1:0]      samples_left_q;
	logic [kstg_pkg::OCT_W-1:0]      octave_q;

	// input stage
	logic                            valid_s1;
	kstg_pkg::kstg_in_t              word_s1;

	// output register
	logic                            out_valid_q;
	kstg_pkg::kstg_out_t             out_word_q;

	logic                            is_tick;
	logic                            out_free;
	logic                            adv_s1;
	logic                            accept;

	assign cfg_ready = 1'b1;
	assign is_tick   = (word_s1.command == kstg_pkg::CMD_TICK);
	assign out_free  = !out_valid_q || !out_stall;
	// non-tick words never need the output register
	assign adv_s1    = valid_s1 && (!is_tick || out_free);
	assign in_stall  = valid_s1 && !adv_s1;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// ---- sample formation ----
	logic [kstg_pkg::SINE_TABLE_BITS-1:0] tab_idx;
	logic [1:0]                           quad;
	logic [kstg_pkg::QUARTER_BITS-1:0]    qr;
	logic [kstg_pkg::QUARTER_BITS-1:0]    qr_rd;
	logic [kstg_pkg::MAG_W-1:0]           mag;
	logic [kstg_pkg::AMP_W+kstg_pkg::MAG_W-1:0] prod;
	logic [kstg_pkg::SAMPLE_W-1:0]        mag_scaled;
	kstg_pkg::kstg_out_t                  tick_word;

	always_comb begin
		tab_idx = phase_q[kstg_pkg::PHASE_BITS-1 -: kstg_pkg::SINE_TABLE_BITS];
		quad    = tab_idx[kstg_pkg::SINE_TABLE_BITS-1 -: 2];
		qr      = tab_idx[kstg_pkg::QUARTER_BITS-1:0];
		// falling quarters read the table mirrored; offset 0 there is the peak
		qr_rd   = quad[0] ? (kstg_pkg::QUARTER_BITS'(0) - qr) : qr;
		if (quad[0] && (qr == '0)) begin
			mag = kstg_pkg::QSINE_PEAK;
		end else begin
			mag = kstg_pkg::QSINE_TAB[qr_rd];
		end
		prod       = (kstg_pkg::AMP_W + kstg_pkg::MAG_W)'(amplitude_q)
		           * (kstg_pkg::AMP_W + kstg_pkg::MAG_W)'(mag);
		mag_scaled = kstg_pkg::SAMPLE_W'(prod[kstg_pkg::AMP_W+kstg_pkg::MAG_W-1 -: kstg_pkg::AMP_W]);
		if (samples_left_q == '0) begin
			tick_word = '0;
		end else begin
			tick_word.sample   = quad[1] ? -$signed(mag_scaled) : $signed(mag_scaled);
			tick_word.sounding = 1'b1;
			tick_word.note_end = (samples_left_q == kstg_pkg::LEN_W'(1));
		end
	end

	// ---- note phase increment ----
	logic [kstg_pkg::PHASE_BITS-1:0] base_step;
	logic [kstg_pkg::PHASE_BITS-1:0] note_step;
	logic [kstg_pkg::OCT_W-1:0]      oct_shift;

	always_comb begin
		base_step = (word_s1.semitone < kstg_pkg::SEMI_W'(kstg_pkg::NUM_SEMITONES))
		          ? kstg_pkg::STEP_TAB[word_s1.semitone] : '0;
		if (octave_q >= kstg_pkg::OCTAVE_BASE) begin
			oct_shift = octave_q - kstg_pkg::OCTAVE_BASE;
			note_step = base_step << oct_shift;
		end else begin
			oct_shift = kstg_pkg::OCTAVE_BASE - octave_q;
			note_step = base_step >> oct_shift;
		end
	end

	// ---- registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q   <= kstg_pkg::AMP_RESET;
			note_length_q <= kstg_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (kstg_pkg::kstg_reg_t'(cfg_index))
				kstg_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data[kstg_pkg::AMP_W-1:0];
				kstg_pkg::REG_NOTE_LENGTH: note_length_q <= cfg_data[kstg_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= '0;
			phase_step_q   <= '0;
			samples_left_q <= '0;
			octave_q       <= kstg_pkg::OCTAVE_BASE;
		end else if (adv_s1) begin
			unique case (word_s1.command)
				kstg_pkg::CMD_TICK: begin
					if (samples_left_q != '0) begin
						phase_q        <= phase_q + phase_step_q;
						samples_left_q <= samples_left_q - kstg_pkg::LEN_W'(1);
					end
				end
				kstg_pkg::CMD_NOTE: begin
					// unmapped semitones are dropped
					if (word_s1.semitone < kstg_pkg::SEMI_W'(kstg_pkg::NUM_SEMITONES)) begin
						phase_q        <= '0;
						phase_step_q   <= note_step;
						samples_left_q <= note_length_q;
					end
				end
				kstg_pkg::CMD_OCT_DOWN: begin
					if (octave_q != '0) begin
						octave_q <= octave_q - kstg_pkg::OCT_W'(1);
					end
				end
				kstg_pkg::CMD_OCT_UP: begin
					if (octave_q < kstg_pkg::OCTAVE_MAX) begin
						octave_q <= octave_q + kstg_pkg::OCT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && is_tick) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_tick) begin
			out_word_q <= tick_word;
		end
	end

	// ---- checks ----
	a_octave_range: assert property (@(posedge clk) disable iff (!arst_n)
		octave_q <= kstg_pkg::OCTAVE_MAX)
		else $error("octave beyond top limit");

	a_silent_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_word_q.sounding) |->
			(out_word_q.sample == '0 && !out_word_q.note_end))
		else $error("silent word carries sample or end mark");

	a_last_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && is_tick && samples_left_q == kstg_pkg::LEN_W'(1)) |=>
			(samples_left_q == '0 && out_word_q.note_end))
		else $error("note did not finish on its marked sample");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && is_tick && out_valid_q && out_stall))
		else $error("input stalled without a blocked tick");

endmodule
